// File: design/tdr_pkg.sv
package tdr_pkg;

    localparam int STORE_DEPTH_DEF = 16;

    localparam int TIME_W = 32;
    localparam int TEMP_W = 16;
    localparam int ENTRY_W = TIME_W + TEMP_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SECONDS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVER_NUM    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVER_DEN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_SECONDS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DETACHED_CODE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INVALID_CODE   = 3'd6;

    // register reset values
    localparam logic [15:0] RST_WINDOW_SECONDS  = 16'd180;
    localparam logic [14:0] RST_DROP_THRESHOLD  = 15'd250;
    localparam logic [7:0]  RST_RECOVER_NUM     = 8'd1;
    localparam logic [7:0]  RST_RECOVER_DEN     = 8'd2;
    localparam logic [15:0] RST_CONFIRM_SECONDS = 16'd1200;
    localparam logic [15:0] RST_DETACHED_CODE   = 16'h8000;
    localparam logic [15:0] RST_INVALID_CODE    = 16'h8001;

    typedef enum logic [1:0] {
        EVT_NONE      = 2'd0,
        EVT_DETECTED  = 2'd1,
        EVT_CONFIRMED = 2'd2,
        EVT_ESCALATED = 2'd3
    } tdr_event_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_RECOV,
        ST_JUDGE,
        ST_FIN
    } tdr_state_t;

endpackage

// File: design/temp_drop_recovery_detector.sv
// Temperature drop and recovery detector. Each request carries a timestamp in
// seconds and a temperature in tenths of a degree; each request yields exactly
// one result (event_res, pending). Samples equal to detached_code or
// invalid_code are skipped straight to the finish state. While no drop is
// active, the block walks its sample store (a ring buffer in a synchronous RAM
// with one write and one read port) once per request: one entry is read per
// cycle, entries older than window_seconds are squeezed out, and the maximum
// of the rest is the reference. A request thus occupies the block longer the
// more entries the store holds, set by the single RAM read port. While a drop
// is active, the recovery test uses two small multipliers in the RECOV and
// JUDGE states. A new request is taken only in the idle state, but a finished
// result sits in an output register, so the next request may start while the
// previous result still waits to be taken.
// There is no clearing pass: the store is tracked by a head pointer and a
// count, and only entries below the count are ever read.
module temp_drop_recovery_detector #(
    parameter int STORE_DEPTH = tdr_pkg::STORE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // sample requests
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [31:0]                       sample_time,
    input  logic signed [15:0]                pit_temp,
    // results
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        event_res,
    output logic                              pending,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tdr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tdr_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0]        window_seconds_reg;
    logic [14:0]        drop_threshold_reg;
    logic [7:0]         recover_num_reg;
    logic [7:0]         recover_den_reg;
    logic [15:0]        confirm_seconds_reg;
    logic signed [15:0] detached_code_reg;
    logic signed [15:0] invalid_code_reg;

    // Always ready: the user must write only while the block is idle; the block does not enforce it.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_seconds_reg  <= tdr_pkg::RST_WINDOW_SECONDS;
            drop_threshold_reg  <= tdr_pkg::RST_DROP_THRESHOLD;
            recover_num_reg     <= tdr_pkg::RST_RECOVER_NUM;
            recover_den_reg     <= tdr_pkg::RST_RECOVER_DEN;
            confirm_seconds_reg <= tdr_pkg::RST_CONFIRM_SECONDS;
            detached_code_reg   <= tdr_pkg::RST_DETACHED_CODE;
            invalid_code_reg    <= tdr_pkg::RST_INVALID_CODE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tdr_pkg::CFG_WINDOW_SECONDS:  window_seconds_reg  <= cfg_data;
                tdr_pkg::CFG_DROP_THRESHOLD:  drop_threshold_reg  <= cfg_data[14:0];
                tdr_pkg::CFG_RECOVER_NUM:     recover_num_reg     <= cfg_data[7:0];
                tdr_pkg::CFG_RECOVER_DEN:     recover_den_reg     <= cfg_data[7:0];
                tdr_pkg::CFG_CONFIRM_SECONDS: confirm_seconds_reg <= cfg_data;
                tdr_pkg::CFG_DETACHED_CODE:   detached_code_reg   <= cfg_data;
                tdr_pkg::CFG_INVALID_CODE:    invalid_code_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sample store: ring buffer of {time, temp}, one write and one read port, registered read
    // ------------------------------------------------------------------
    logic [tdr_pkg::ENTRY_W-1:0] store_mem [STORE_DEPTH];
    logic [tdr_pkg::ENTRY_W-1:0] rd_data_reg;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [tdr_pkg::ENTRY_W-1:0] wr_data;

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    tdr_pkg::tdr_state_t  state_reg, state_next;
    tdr_pkg::tdr_event_t  evt_reg, evt_next;
    logic [AW-1:0]        head_reg, head_next;
    logic [CW-1:0]        count_reg, count_next;
    logic                 active_reg, active_next;
    logic signed [15:0]   ref_temp_reg, ref_temp_next;
    logic signed [15:0]   low_temp_reg, low_temp_next;
    logic [31:0]          detect_time_reg, detect_time_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic                 out_valid_reg, out_valid_next;

    // working registers, loaded before use
    logic [31:0]          now_reg, now_next;
    logic signed [15:0]   temp_reg, temp_next;
    logic [AW-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0]        rd_cnt_reg, rd_cnt_next;
    logic [CW-1:0]        keep_reg, keep_next;
    logic signed [15:0]   max_reg, max_next;
    logic signed [25:0]   prod_rec_reg, prod_rec_next;
    logic signed [25:0]   prod_drop_reg, prod_drop_next;
    logic                 tout_reg, tout_next;
    logic [1:0]           out_event_reg, out_event_next;
    logic                 out_pending_reg, out_pending_next;

    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
        ring_inc = (p == AW'(STORE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // scan datapath: age test and running maximum on the entry just read
    logic [31:0]        ent_time;
    logic signed [15:0] ent_temp;
    logic [31:0]        ent_limit;
    logic               ent_keep;
    logic               scan_issue;

    assign ent_time   = rd_data_reg[tdr_pkg::ENTRY_W-1:tdr_pkg::TEMP_W];
    assign ent_temp   = rd_data_reg[tdr_pkg::TEMP_W-1:0];
    assign ent_limit  = ent_time + {16'd0, window_seconds_reg};
    assign ent_keep   = ent_limit >= now_reg;
    assign scan_issue = rd_cnt_reg != count_reg;

    // drop test against the window maximum
    logic signed [16:0] ref_diff;
    logic               drop_hit;
    logic               store_full;

    assign ref_diff   = {max_reg[15], max_reg} - {temp_reg[15], temp_reg};
    assign drop_hit   = (keep_reg != '0) && (ref_diff >= $signed({2'b00, drop_threshold_reg}));
    assign store_full = keep_reg == CW'(STORE_DEPTH);

    // recovery datapath, operands for the two multipliers
    logic signed [15:0] low_new;
    logic signed [25:0] drop_ext;
    logic signed [25:0] rec_ext;
    logic [31:0]        since_detect;

    assign low_new      = (temp_reg < low_temp_reg) ? temp_reg : low_temp_reg;
    assign drop_ext     = 26'(ref_temp_reg) - 26'(low_new);
    assign rec_ext      = 26'(temp_reg) - 26'(low_new);
    assign since_detect = now_reg - detect_time_reg;

    logic is_sentinel;
    assign is_sentinel = (pit_temp == detached_code_reg) || (pit_temp == invalid_code_reg);

    assign in_ready  = state_reg == tdr_pkg::ST_IDLE;
    assign out_valid = out_valid_reg;
    assign event_res = out_event_reg;
    assign pending   = out_pending_reg;

    // ------------------------------------------------------------------
    // Next state and datapath control
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        evt_next         = evt_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        active_next      = active_reg;
        ref_temp_next    = ref_temp_reg;
        low_temp_next    = low_temp_reg;
        detect_time_next = detect_time_reg;
        rd_pend_next     = 1'b0;
        out_valid_next   = out_valid_reg && !out_ready;
        now_next         = now_reg;
        temp_next        = temp_reg;
        rd_ptr_next      = rd_ptr_reg;
        wr_ptr_next      = wr_ptr_reg;
        rd_cnt_next      = rd_cnt_reg;
        keep_next        = keep_reg;
        max_next         = max_reg;
        prod_rec_next    = prod_rec_reg;
        prod_drop_next   = prod_drop_reg;
        tout_next        = tout_reg;
        out_event_next   = out_event_reg;
        out_pending_next = out_pending_reg;
        wr_en            = 1'b0;
        wr_addr          = wr_ptr_reg;
        wr_data          = {now_reg, temp_reg};

        case (state_reg)
            tdr_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    now_next    = sample_time;
                    temp_next   = pit_temp;
                    rd_ptr_next = head_reg;
                    wr_ptr_next = head_reg;
                    rd_cnt_next = '0;
                    keep_next   = '0;
                    evt_next    = tdr_pkg::EVT_NONE;
                    // skip sentinel codes, else branch on drop state
                    if (is_sentinel)
                        state_next = tdr_pkg::ST_FIN;
                    else if (active_reg)
                        state_next = tdr_pkg::ST_RECOV;
                    else
                        state_next = tdr_pkg::ST_SCAN;
                end
            end

            tdr_pkg::ST_SCAN:
            begin
                // issue the next read; the read address always runs ahead of
                // the compaction write, so no forwarding is needed
                if (scan_issue)
                begin
                    rd_ptr_next  = ring_inc(rd_ptr_reg);
                    rd_cnt_next  = rd_cnt_reg + 1'b1;
                    rd_pend_next = 1'b1;
                end
                // retire the entry read last cycle: keep it or drop it
                if (rd_pend_reg && ent_keep)
                begin
                    wr_en       = 1'b1;
                    wr_addr     = wr_ptr_reg;
                    wr_data     = rd_data_reg;
                    wr_ptr_next = ring_inc(wr_ptr_reg);
                    keep_next   = keep_reg + 1'b1;
                    if (keep_reg == '0 || ent_temp > max_reg)
                        max_next = ent_temp;
                end
                if (!scan_issue && !rd_pend_reg)
                    state_next = tdr_pkg::ST_DECIDE;
            end

            tdr_pkg::ST_DECIDE:
            begin
                if (drop_hit)
                begin
                    active_next      = 1'b1;
                    ref_temp_next    = max_reg;
                    low_temp_next    = temp_reg;
                    detect_time_next = now_reg;
                    count_next       = '0;
                    evt_next         = tdr_pkg::EVT_DETECTED;
                end
                else
                begin
                    // append; a full ring overwrites its oldest entry
                    wr_en   = 1'b1;
                    wr_addr = wr_ptr_reg;
                    wr_data = {now_reg, temp_reg};
                    if (store_full)
                    begin
                        head_next  = ring_inc(head_reg);
                        count_next = keep_reg;
                    end
                    else
                    begin
                        count_next = keep_reg + 1'b1;
                    end
                end
                state_next = tdr_pkg::ST_FIN;
            end

            tdr_pkg::ST_RECOV:
            begin
                low_temp_next  = low_new;
                prod_rec_next  = rec_ext * $signed({18'd0, recover_den_reg});
                prod_drop_next = drop_ext * $signed({18'd0, recover_num_reg});
                tout_next      = since_detect >= {16'd0, confirm_seconds_reg};
                state_next     = tdr_pkg::ST_JUDGE;
            end

            tdr_pkg::ST_JUDGE:
            begin
                if (prod_rec_reg >= prod_drop_reg)
                    evt_next = tdr_pkg::EVT_CONFIRMED;
                else if (tout_reg)
                    evt_next = tdr_pkg::EVT_ESCALATED;
                else
                    evt_next = tdr_pkg::EVT_NONE;
                // restart the store holding only this sample
                if ((prod_rec_reg >= prod_drop_reg) || tout_reg)
                begin
                    active_next = 1'b0;
                    count_next  = CW'(1);
                    wr_en       = 1'b1;
                    wr_addr     = head_reg;
                    wr_data     = {now_reg, temp_reg};
                end
                state_next = tdr_pkg::ST_FIN;
            end

            tdr_pkg::ST_FIN:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    out_event_next   = evt_reg;
                    out_pending_next = active_reg;
                    state_next       = tdr_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tdr_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= tdr_pkg::ST_IDLE;
            evt_reg         <= tdr_pkg::EVT_NONE;
            head_reg        <= '0;
            count_reg       <= '0;
            active_reg      <= 1'b0;
            ref_temp_reg    <= '0;
            low_temp_reg    <= '0;
            detect_time_reg <= '0;
            rd_pend_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            evt_reg         <= evt_next;
            head_reg        <= head_next;
            count_reg       <= count_next;
            active_reg      <= active_next;
            ref_temp_reg    <= ref_temp_next;
            low_temp_reg    <= low_temp_next;
            detect_time_reg <= detect_time_next;
            rd_pend_reg     <= rd_pend_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg         <= now_next;
        temp_reg        <= temp_next;
        rd_ptr_reg      <= rd_ptr_next;
        wr_ptr_reg      <= wr_ptr_next;
        rd_cnt_reg      <= rd_cnt_next;
        keep_reg        <= keep_next;
        max_reg         <= max_next;
        prod_rec_reg    <= prod_rec_next;
        prod_drop_reg   <= prod_drop_next;
        tout_reg        <= tout_next;
        out_event_reg   <= out_event_next;
        out_pending_reg <= out_pending_next;
    end

    // store RAM: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_mem[wr_addr] <= wr_data;
        rd_data_reg <= store_mem[rd_ptr_reg];
    end

endmodule

// File: sim/tb_temp_drop_recovery_detector.sv
module tb_temp_drop_recovery_detector;

    localparam int DEPTH         = tdr_pkg::STORE_DEPTH_DEF;
    localparam int N_PHASES      = 8;
    localparam int PHASE_ITEMS   = 250;   // counted requests per phase, sentinels excluded
    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
    localparam int SETTLE_CYCLES = 25;    // settle wait after every result has drained
    localparam int STALL_LIMIT   = 5000;  // cycles with no handshake at all

    // one row of the opening stimulus table
    typedef struct packed {
        logic [31:0]         stamp;
        logic signed [15:0]  temp;
        logic                fixed;   // expectation typed into the row
        tdr_pkg::tdr_event_t evt;
        logic                pend;
    } plan_row_t;

    typedef struct packed {
        tdr_pkg::tdr_event_t evt;
        logic                pend;
    } outcome_t;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    logic [31:0]                    sample_time;
    logic signed [15:0]             pit_temp;
    logic                           out_valid;
    logic                           out_ready;
    logic [1:0]                     event_res;
    logic                           pending;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [tdr_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [tdr_pkg::CFG_DATA_W-1:0] cfg_data;

    temp_drop_recovery_detector dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .sample_time (sample_time),
        .pit_temp    (pit_temp),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .event_res   (event_res),
        .pending     (pending),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor state: the sample window, the drop tracker and a shadow of
    // every configuration register.
    // ------------------------------------------------------------------
    logic [31:0]        win_time [DEPTH];
    int                 win_temp [DEPTH];
    int                 win_cnt;
    logic               drop_on;
    int                 ref_level;
    int                 low_level;
    logic [31:0]        drop_stamp;

    logic [15:0]        r_window;
    logic [14:0]        r_thresh;
    logic [7:0]         r_num;
    logic [7:0]         r_den;
    logic [15:0]        r_confirm;
    logic signed [15:0] r_detached;
    logic signed [15:0] r_invalid;

    outcome_t           due_events [$];
    plan_row_t          opening_rows [$];
    outcome_t           got;
    int                 err_count;

    // receiver and sender shaping
    logic               no_gaps;
    logic               hold_go;
    logic               hold_spent;
    int                 hold_left;
    int                 stall_cycles;

    function automatic void shadow_reset();
        win_cnt    = 0;
        drop_on    = 1'b0;
        ref_level  = 0;
        low_level  = 0;
        drop_stamp = '0;
        r_window   = tdr_pkg::RST_WINDOW_SECONDS;
        r_thresh   = tdr_pkg::RST_DROP_THRESHOLD;
        r_num      = tdr_pkg::RST_RECOVER_NUM;
        r_den      = tdr_pkg::RST_RECOVER_DEN;
        r_confirm  = tdr_pkg::RST_CONFIRM_SECONDS;
        r_detached = tdr_pkg::RST_DETACHED_CODE;
        r_invalid  = tdr_pkg::RST_INVALID_CODE;
    endfunction

    function automatic void apply_reg(input logic [tdr_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [15:0] data);
        case (idx)
            tdr_pkg::CFG_WINDOW_SECONDS:  r_window   = data;
            tdr_pkg::CFG_DROP_THRESHOLD:  r_thresh   = data[14:0];
            tdr_pkg::CFG_RECOVER_NUM:     r_num      = data[7:0];
            tdr_pkg::CFG_RECOVER_DEN:     r_den      = data[7:0];
            tdr_pkg::CFG_CONFIRM_SECONDS: r_confirm  = data;
            tdr_pkg::CFG_DETACHED_CODE:   r_detached = data;
            tdr_pkg::CFG_INVALID_CODE:    r_invalid  = data;
            default: ;
        endcase
    endfunction

    // Squeeze out entries whose (time + window) mod 2^32 falls below now.
    function automatic void prune_window(input logic [31:0] now);
        int          keep;
        logic [31:0] horizon;
        keep = 0;
        for (int i = 0; i < win_cnt; i++) begin
            horizon = win_time[i] + {16'd0, r_window};
            if (horizon >= now) begin
                win_time[keep] = win_time[i];
                win_temp[keep] = win_temp[i];
                keep++;
            end
        end
        win_cnt = keep;
    endfunction

    // Append after pruning; a full window loses its oldest entry first.
    function automatic void push_window(input logic [31:0] now, input int t);
        prune_window(now);
        if (win_cnt >= DEPTH) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                win_time[i] = win_time[i+1];
                win_temp[i] = win_temp[i+1];
            end
            win_cnt = DEPTH - 1;
        end
        win_time[win_cnt] = now;
        win_temp[win_cnt] = t;
        win_cnt++;
    endfunction

    function automatic outcome_t predict_drop_event(input logic [31:0] now,
                                                    input logic signed [15:0] smp);
        outcome_t    res;
        int          t;
        int          peak;
        longint      drop;
        longint      rec;
        logic [31:0] elapsed;
        t       = smp;
        res.evt = tdr_pkg::EVT_NONE;
        if (smp == r_detached || smp == r_invalid) begin
            // sentinel: state untouched
        end else if (!drop_on) begin
            prune_window(now);
            if (win_cnt > 0) begin
                peak = win_temp[0];
                for (int i = 1; i < win_cnt; i++)
                    if (win_temp[i] > peak)
                        peak = win_temp[i];
                if (longint'(peak) - longint'(t) >= longint'(r_thresh)) begin
                    drop_on    = 1'b1;
                    ref_level  = peak;
                    low_level  = t;
                    drop_stamp = now;
                    win_cnt    = 0;
                    res.evt    = tdr_pkg::EVT_DETECTED;
                end
            end
            if (res.evt != tdr_pkg::EVT_DETECTED)
                push_window(now, t);
        end else begin
            if (t < low_level)
                low_level = t;
            drop    = longint'(ref_level) - longint'(low_level);
            rec     = longint'(t) - longint'(low_level);
            elapsed = now - drop_stamp;
            // recovery wins over the timeout
            if (rec * longint'(r_den) >= drop * longint'(r_num))
                res.evt = tdr_pkg::EVT_CONFIRMED;
            else if (elapsed >= {16'd0, r_confirm})
                res.evt = tdr_pkg::EVT_ESCALATED;
            if (res.evt != tdr_pkg::EVT_NONE) begin
                drop_on = 1'b0;
                win_cnt = 0;
                push_window(now, t);
            end
        end
        res.pend = drop_on;
        return res;
    endfunction

    function automatic plan_row_t plan_row(input logic [31:0] stamp, input int temp,
                                           input logic fixed,
                                           input tdr_pkg::tdr_event_t evt,
                                           input logic pend);
        plan_row_t r;
        r.stamp = stamp;
        r.temp  = temp[15:0];
        r.fixed = fixed;
        r.evt   = evt;
        r.pend  = pend;
        return r;
    endfunction

    function automatic logic signed [15:0] clamp_temp(input int v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    // Favor the ends of a register's range.
    function automatic int pick_setting(input int lo, input int hi);
        int r;
        r = $urandom_range(0, 3);
        if (r == 0)
            return lo;
        if (r == 1)
            return hi;
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // Offer one request; hold valid and payload until in_ready is seen.
    task automatic send_sample(input logic [31:0] stamp, input logic signed [15:0] temp);
        while (!no_gaps && $urandom_range(0, 99) < 38) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        sample_time <= stamp;
        pit_temp    <= temp;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Predict first, then offer; a typed expectation overrides the prediction.
    task automatic run_sample(input logic [31:0] stamp, input logic signed [15:0] temp,
                              input logic fixed, input tdr_pkg::tdr_event_t evt,
                              input logic pend);
        outcome_t want;
        want = predict_drop_event(stamp, temp);
        if (fixed) begin
            want.evt  = evt;
            want.pend = pend;
        end
        due_events.push_back(want);
        send_sample(stamp, temp);
    endtask

    // Drop valid, let every result drain, then give the block time to settle.
    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (due_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [tdr_pkg::CFG_IDX_W-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[15:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_reg(idx, value[15:0]);
    endtask

    task automatic load_settings(input int win, input int thr, input int num, input int den,
                                 input int conf, input int det, input int inv);
        wait_quiet();
        write_reg(tdr_pkg::CFG_WINDOW_SECONDS, win);
        write_reg(tdr_pkg::CFG_DROP_THRESHOLD, thr);
        write_reg(tdr_pkg::CFG_RECOVER_NUM, num);
        write_reg(tdr_pkg::CFG_RECOVER_DEN, den);
        write_reg(tdr_pkg::CFG_CONFIRM_SECONDS, conf);
        write_reg(tdr_pkg::CFG_DETACHED_CODE, det);
        write_reg(tdr_pkg::CFG_INVALID_CODE, inv);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, a gap-free stretch when asked, and
    // one long hold-off counted here so the block fills and stalls input.
    // ------------------------------------------------------------------
    initial begin
        out_ready  = 1'b0;
        hold_left  = 0;
        hold_spent = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (hold_go && !hold_spent) begin
                hold_spent = 1'b1;
                hold_left  = HOLD_CYCLES;
                out_ready  <= 1'b0;
            end else begin
                out_ready <= no_gaps || ($urandom_range(0, 99) >= 38);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare each taken result with the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (due_events.size() == 0) begin
                $display("%0t: result with nothing expected: event_res %0d pending %0d",
                         $time, event_res, pending);
                err_count++;
            end else begin
                got = due_events.pop_front();
                if (event_res !== got.evt) begin
                    $display("%0t: event_res mismatch, expected %0d, actual %0d",
                             $time, got.evt, event_res);
                    err_count++;
                end
                if (pending !== got.pend) begin
                    $display("%0t: pending mismatch, expected %0d, actual %0d",
                             $time, got.pend, pending);
                    err_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if no channel moves a request for too long.
    // ------------------------------------------------------------------
    initial begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("tb_temp_drop_recovery_detector: errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        logic [31:0]        now;
        logic signed [15:0] smp;
        int                 lvl;
        int                 val;
        int                 kind;
        int                 counted;
        int                 w, th, nu, de, co, dc, ic;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        sample_time = '0;
        pit_temp    = '0;
        cfg_valid   = 1'b0;
        cfg_index   = tdr_pkg::CFG_WINDOW_SECONDS;
        cfg_data    = '0;
        no_gaps     = 1'b0;
        hold_go     = 1'b0;
        err_count   = 0;
        shadow_reset();

        // Opening table, run at the register reset values (window 180, threshold
        // 250, half recovery, 1200 s timeout). Typed rows follow directly.
        opening_rows.push_back(plan_row(32'd0, 1000, 1'b1, tdr_pkg::EVT_NONE, 1'b0));
        // both sentinel codes at their reset values are skipped
        opening_rows.push_back(plan_row(32'd10, -32768, 1'b1, tdr_pkg::EVT_NONE, 1'b0));
        opening_rows.push_back(plan_row(32'd20, -32767, 1'b1, tdr_pkg::EVT_NONE, 1'b0));
        // 1000 - 700 reaches the threshold
        opening_rows.push_back(plan_row(32'd30, 700, 1'b1, tdr_pkg::EVT_DETECTED, 1'b1));
        opening_rows.push_back(plan_row(32'd40, 600, 1'b1, tdr_pkg::EVT_NONE, 1'b1));
        // sentinel while a drop is active shows pending unchanged
        opening_rows.push_back(plan_row(32'd50, -32768, 1'b1, tdr_pkg::EVT_NONE, 1'b1));
        // recovered exactly half of the drop
        opening_rows.push_back(plan_row(32'd60, 800, 1'b1, tdr_pkg::EVT_CONFIRMED, 1'b0));
        opening_rows.push_back(plan_row(32'd70, 32767, 1'b1, tdr_pkg::EVT_NONE, 1'b0));
        // widest possible drop
        opening_rows.push_back(plan_row(32'd80, -32766, 1'b1, tdr_pkg::EVT_DETECTED, 1'b1));
        opening_rows.push_back(plan_row(32'd2000, -32766, 1'b1, tdr_pkg::EVT_ESCALATED,
                                        1'b0));
        // one second past the window edge evicts the only entry
        opening_rows.push_back(plan_row(32'd2181, 500, 1'b0, tdr_pkg::EVT_NONE, 1'b0));
        // age test wraps around 2^32
        opening_rows.push_back(plan_row(32'hffff_fff0, 500, 1'b0, tdr_pkg::EVT_NONE, 1'b0));
        opening_rows.push_back(plan_row(32'd5, 200, 1'b0, tdr_pkg::EVT_NONE, 1'b0));
        // one second short of the timeout, then exactly on it
        opening_rows.push_back(plan_row(32'd1204, 200, 1'b0, tdr_pkg::EVT_NONE, 1'b0));
        opening_rows.push_back(plan_row(32'd1205, 199, 1'b0, tdr_pkg::EVT_NONE, 1'b0));
        opening_rows.push_back(plan_row(32'hffff_ffff, -100, 1'b0, tdr_pkg::EVT_NONE, 1'b0));
        opening_rows.push_back(plan_row(32'd0, 400, 1'b0, tdr_pkg::EVT_NONE, 1'b0));
        opening_rows.push_back(plan_row(32'd1, 100, 1'b0, tdr_pkg::EVT_NONE, 1'b0));
        // recovery and timeout both true: recovery wins
        opening_rows.push_back(plan_row(32'd2000, 250, 1'b0, tdr_pkg::EVT_NONE, 1'b0));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening_rows[i])
            run_sample(opening_rows[i].stamp, opening_rows[i].temp, opening_rows[i].fixed,
                       opening_rows[i].evt, opening_rows[i].pend);

        // Random phases, each with its own register settings. The first two
        // pin the extremes, the third returns to reset values without gaps.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin
                    w = 65535; th = 1; nu = 0; de = 1; co = 0; dc = 32767; ic = -32768;
                end
                1: begin
                    w = 0; th = 32767; nu = 255; de = 255; co = 65535;
                    dc = pick_setting(-32768, 32767); ic = pick_setting(-32768, 32767);
                end
                2: begin
                    w = 180; th = 250; nu = 1; de = 2; co = 1200; dc = -32768; ic = -32767;
                end
                3: begin
                    w = 65535; th = 3000; nu = 1; de = 1; co = 600;
                    dc = pick_setting(-32768, 32767); ic = pick_setting(-32768, 32767);
                end
                default: begin
                    w  = pick_setting(0, 65535);
                    th = pick_setting(1, 32767);
                    nu = pick_setting(0, 255);
                    de = pick_setting(1, 255);
                    co = pick_setting(0, 65535);
                    dc = pick_setting(-32768, 32767);
                    ic = pick_setting(-32768, 32767);
                end
            endcase
            load_settings(w, th, nu, de, co, dc, ic);
            no_gaps <= (ph == 2);

            lvl     = int'($urandom_range(0, 60000)) - 30000;
            now     = $urandom();
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                // advance time: mostly inside the window, sometimes past the
                // timeout, now and then anywhere in the 32-bit range
                kind = $urandom_range(0, 99);
                if (kind < 3)
                    now = $urandom();
                else if (kind < 12)
                    now = now + $urandom_range(0, r_confirm + 16);
                else
                    now = now + $urandom_range(0, r_window / 32 + 2);

                // shape the temperature around a drifting level
                kind = $urandom_range(0, 99);
                if (kind < 6) begin
                    smp = ($urandom_range(0, 1) != 0) ? r_detached : r_invalid;
                end else if (kind < 14) begin
                    val = $urandom();
                    smp = val[15:0];
                end else if (kind < 30) begin
                    smp = clamp_temp(lvl - int'(r_thresh) - int'($urandom_range(0, 200)));
                end else if (kind < 45) begin
                    smp = clamp_temp(lvl - int'($urandom_range(0, r_thresh)));
                end else begin
                    if (kind > 95)
                        lvl = int'($urandom_range(0, 60000)) - 30000;
                    smp = clamp_temp(lvl + int'($urandom_range(0, 40)) - 20);
                end

                run_sample(now, smp, 1'b0, tdr_pkg::EVT_NONE, 1'b0);
                if (smp != r_detached && smp != r_invalid)
                    counted++;
                // ask the receiver for its long hold-off while requests keep coming
                if (ph == 3 && counted == 40)
                    hold_go <= 1'b1;
            end
        end

        wait_quiet();
        if (err_count == 0)
            $display("tb_temp_drop_recovery_detector: clean");
        else
            $display("tb_temp_drop_recovery_detector: errors");
        $finish;
    end

endmodule
